### design/pid_trajectory_tracker_defines.svh
// Assertion helpers shared by the block's modules.
`ifndef PID_TRAJECTORY_TRACKER_DEFINES_SVH
`define PID_TRAJECTORY_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PTT_ASSERT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PTT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/ptt_pkg.sv
package ptt_pkg;

   localparam int TRAJ_DEPTH = 2048;
   localparam int TRAJ_AW    = $clog2(TRAJ_DEPTH);

   localparam int CMD_W  = 2;
   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;
   localparam int ENC_W  = 16;
   localparam int LEN_W  = 12;
   localparam int CSR_AW = 4;

   localparam int TRAJ_LEN_MAX = 2048;
   localparam int Q_FRAC       = 16;
   localparam int ROUND_HALF   = 32768;
   localparam int INTEGRAL_CAP = 1000 * 65536;

   // count*360*65536/1336 = count*17659 + count*67/167, rounded to nearest
   localparam int ANGLE_WHOLE    = 17659;
   localparam int ANGLE_FRAC_NUM = 67;
   localparam int ANGLE_DEN      = 167;
   localparam int ANGLE_BIAS     = 83;
   localparam int ANGLE_RECIP    = 25718367;  // floor(2^32 / 167)
   localparam int ANGLE_SHIFT    = 32;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_START = 2'd1,
      CMD_TICK  = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      REG_GAIN_P   = 2'd0,
      REG_GAIN_I   = 2'd1,
      REG_GAIN_D   = 2'd2,
      REG_TRAJ_LEN = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG0,
      ST_ANG1,
      ST_ANG2,
      ST_ANG3,
      ST_ERR,
      ST_INTG,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] gain_p;
      logic signed [DATA_W-1:0] gain_i;
      logic signed [DATA_W-1:0] gain_d;
      logic [LEN_W-1:0]         traj_len;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic capture;
      logic ang0;
      logic ang1;
      logic ang2;
      logic ang3;
      logic err;
      logic intg;
      logic mul0;
      logic mul1;
      logic mul2;
      logic mul3;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
   } dp_status_type;

endpackage

### design/ptt_csr.sv
module ptt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ptt_pkg::CSR_AW-1:0]  paddr,
   input  logic [ptt_pkg::DATA_W-1:0]  pwdata,
   output logic [ptt_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output ptt_pkg::cfg_type            cfg
);
   import ptt_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_idx;
   logic          wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_index_type'(paddr[3:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GAIN_P:   cfg_in.gain_p   = pwdata;
            REG_GAIN_I:   cfg_in.gain_i   = pwdata;
            REG_GAIN_D:   cfg_in.gain_d   = pwdata;
            REG_TRAJ_LEN: cfg_in.traj_len = pwdata[LEN_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p   <= '0;
         cfg_ff.gain_i   <= '0;
         cfg_ff.gain_d   <= '0;
         cfg_ff.traj_len <= LEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_GAIN_P:   prdata = cfg_ff.gain_p;
         REG_GAIN_I:   prdata = cfg_ff.gain_i;
         REG_GAIN_D:   prdata = cfg_ff.gain_d;
         REG_TRAJ_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_ff.traj_len};
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### design/ptt_datapath.sv
`include "pid_trajectory_tracker_defines.svh"

module ptt_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ptt_pkg::cfg_type                  cfg,
   input  ptt_pkg::dp_cmd_type               cmd,
   output ptt_pkg::dp_status_type            status,
   input  logic [ptt_pkg::IDX_W-1:0]         point_index,
   input  logic signed [ptt_pkg::DATA_W-1:0] point_angle,
   input  logic signed [ptt_pkg::ENC_W-1:0]  encoder_count,
   output logic signed [ptt_pkg::DATA_W-1:0] torque,
   output logic signed [ptt_pkg::DATA_W-1:0] measured_angle,
   output logic [ptt_pkg::IDX_W-1:0]         sample_index,
   output logic                              last
);
   import ptt_pkg::*;

   localparam logic signed [32:0] CAP33 = 33'(INTEGRAL_CAP);
   localparam logic signed [31:0] CAP32 = 32'(INTEGRAL_CAP);

   function automatic logic [31:0] sat_33(input logic [32:0] v);
      logic [31:0] r;
      if (v[32] != v[31]) r = v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic [31:0] sat_50(input logic [49:0] v);
      logic [31:0] r;
      if ((&v[49:31]) || !(|v[49:31])) r = v[31:0];
      else r = v[49] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      return r;
   endfunction

   logic [DATA_W-1:0] traj_mem [TRAJ_DEPTH];

   // control state
   logic [IDX_W-1:0]         counter_ff;
   logic signed [DATA_W-1:0] integ_ff;
   logic signed [DATA_W-1:0] prev_ff;

   // working registers
   logic [DATA_W-1:0]        desired_raw_ff;
   logic                     desired_ok_ff;
   logic [ENC_W-1:0]         abs_ff;
   logic                     neg_ff;
   logic [29:0]              base_ff;
   logic [21:0]              x_ff;
   logic [14:0]              qe_ff;
   logic [14:0]              q_ff;
   logic signed [DATA_W-1:0] actual_ff;
   logic signed [DATA_W-1:0] err_ff;
   logic signed [DATA_W-1:0] diff_ff;
   logic signed [63:0]       prod_ff;
   logic signed [65:0]       acc_ff;

   // result registers
   logic signed [DATA_W-1:0] torque_ff;
   logic signed [DATA_W-1:0] actual_out_ff;
   logic [IDX_W-1:0]         index_out_ff;
   logic                     last_out_ff;

   logic [ENC_W-1:0]         enc_abs;
   logic [46:0]              recip_prod;
   logic [21:0]              rem;
   logic signed [31:0]       mag_s;
   logic signed [DATA_W-1:0] desired;
   logic [32:0]              err_wide;
   logic signed [32:0]       integ_sum;
   logic signed [DATA_W-1:0] integ_next;
   logic [32:0]              diff_wide;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [63:0]       mul_p;
   logic signed [65:0]       prod_ext;
   logic [LEN_W-1:0]         len;
   logic [TRAJ_AW-1:0]       wr_addr;
   logic [TRAJ_AW-1:0]       rd_addr;

   assign wr_addr = TRAJ_AW'(point_index);
   assign rd_addr = TRAJ_AW'(counter_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && (32'(point_index) < TRAJ_DEPTH)) begin
         traj_mem[wr_addr] <= point_angle;
      end
      if (cmd.capture) begin
         desired_raw_ff <= traj_mem[rd_addr];
      end
   end

   assign enc_abs    = encoder_count[ENC_W-1] ? (~encoder_count + 1'b1) : encoder_count;
   assign recip_prod = 47'(x_ff) * 47'(ANGLE_RECIP);
   assign rem        = x_ff - 22'(32'(qe_ff) * 32'(ANGLE_DEN));
   assign mag_s      = $signed({1'b0, 31'(base_ff) + 31'(q_ff)});
   assign desired    = desired_ok_ff ? $signed(desired_raw_ff) : '0;
   assign err_wide   = {desired[31], desired} - {actual_ff[31], actual_ff};
   assign integ_sum  = $signed({integ_ff[31], integ_ff}) + $signed({err_ff[31], err_ff});
   assign diff_wide  = {err_ff[31], err_ff} - {prev_ff[31], prev_ff};

   always_comb begin
      if (integ_sum > CAP33) integ_next = CAP32;
      else if (integ_sum < -CAP33) integ_next = -CAP32;
      else integ_next = integ_sum[31:0];
   end

   // one shared multiplier, operands picked by step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.mul0) begin
         mul_a = cfg.gain_p;
         mul_b = err_ff;
      end else if (cmd.mul1) begin
         mul_a = cfg.gain_i;
         mul_b = integ_ff;
      end else if (cmd.mul2) begin
         mul_a = cfg.gain_d;
         mul_b = diff_ff;
      end
   end

   assign mul_p    = mul_a * mul_b;
   assign prod_ext = $signed({{2{prod_ff[63]}}, prod_ff});

   // run length limited to 1..2048
   always_comb begin
      if (cfg.traj_len == '0) len = LEN_W'(1);
      else if (cfg.traj_len > LEN_W'(TRAJ_LEN_MAX)) len = LEN_W'(TRAJ_LEN_MAX);
      else len = cfg.traj_len;
   end

   assign status.last = (({1'b0, counter_ff} + LEN_W'(1)) >= len);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         abs_ff        <= enc_abs;
         neg_ff        <= encoder_count[ENC_W-1];
         desired_ok_ff <= (32'(counter_ff) < TRAJ_DEPTH);
      end
      if (cmd.ang0) begin
         base_ff <= 30'(32'(abs_ff) * 32'(ANGLE_WHOLE));
         x_ff    <= 22'(32'(abs_ff) * 32'(ANGLE_FRAC_NUM) + 32'(ANGLE_BIAS));
      end
      if (cmd.ang1) begin
         qe_ff <= recip_prod[ANGLE_SHIFT +: 15];
      end
      if (cmd.ang2) begin
         q_ff <= qe_ff + 15'(rem >= 22'(ANGLE_DEN));
      end
      if (cmd.ang3) begin
         actual_ff <= neg_ff ? -mag_s : mag_s;
      end
      if (cmd.err) begin
         err_ff <= sat_33(err_wide);
      end
      if (cmd.intg) begin
         diff_ff <= sat_33(diff_wide);
      end
      if (cmd.mul0 || cmd.mul1 || cmd.mul2) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul1) begin
         acc_ff <= prod_ext + 66'(ROUND_HALF);
      end else if (cmd.mul2 || cmd.mul3) begin
         acc_ff <= acc_ff + prod_ext;
      end
      if (cmd.finish) begin
         torque_ff     <= sat_50(acc_ff[65:Q_FRAC]);
         actual_out_ff <= actual_ff;
         index_out_ff  <= counter_ff;
         last_out_ff   <= status.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         integ_ff   <= '0;
         prev_ff    <= '0;
      end else begin
         if (cmd.intg) begin
            integ_ff <= integ_next;
            prev_ff  <= err_ff;
         end
         if (cmd.finish) begin
            if (status.last) begin
               counter_ff <= '0;
               integ_ff   <= '0;
               prev_ff    <= '0;
            end else begin
               counter_ff <= counter_ff + 1'b1;
            end
         end
      end
   end

   assign torque         = torque_ff;
   assign measured_angle = actual_out_ff;
   assign sample_index   = index_out_ff;
   assign last           = last_out_ff;

   `PTT_ASSERT(integ_in_range, clock, reset, 1'b1, (integ_ff <= CAP32) && (integ_ff >= -CAP32), "integral beyond cap")
   `PTT_ASSERT_NEXT(angle_quot_exact, clock, reset, cmd.ang2, (x_ff - 22'(32'(q_ff) * 32'(ANGLE_DEN))) < 22'(ANGLE_DEN), "angle quotient off by one")

endmodule

### design/ptt_control.sv
`include "pid_trajectory_tracker_defines.svh"

module ptt_control (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ptt_pkg::CMD_W-1:0]  req_command,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  ptt_pkg::dp_status_type     status,
   output ptt_pkg::dp_cmd_type        dp_cmd
);
   import ptt_pkg::*;

   state_type state_ff, state_in;
   logic      tracking_ff, tracking_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      run_tick;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign run_tick  = accept && (req_command == CMD_TICK) && tracking_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (run_tick) state_in = ST_ANG0;
         ST_ANG0: state_in = ST_ANG1;
         ST_ANG1: state_in = ST_ANG2;
         ST_ANG2: state_in = ST_ANG3;
         ST_ANG3: state_in = ST_ERR;
         ST_ERR:  state_in = ST_INTG;
         ST_INTG: state_in = ST_MUL0;
         ST_MUL0: state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_OUT;
         ST_OUT:  if (slot_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd         = '0;
      dp_cmd.load    = accept && (req_command == CMD_LOAD);
      dp_cmd.capture = run_tick;
      unique case (state_ff)
         ST_ANG0: dp_cmd.ang0   = 1'b1;
         ST_ANG1: dp_cmd.ang1   = 1'b1;
         ST_ANG2: dp_cmd.ang2   = 1'b1;
         ST_ANG3: dp_cmd.ang3   = 1'b1;
         ST_ERR:  dp_cmd.err    = 1'b1;
         ST_INTG: dp_cmd.intg   = 1'b1;
         ST_MUL0: dp_cmd.mul0   = 1'b1;
         ST_MUL1: dp_cmd.mul1   = 1'b1;
         ST_MUL2: dp_cmd.mul2   = 1'b1;
         ST_MUL3: dp_cmd.mul3   = 1'b1;
         ST_OUT:  dp_cmd.finish = slot_free;
         default: dp_cmd.finish = 1'b0;
      endcase
   end

   always_comb begin
      tracking_in = tracking_ff;
      if (accept && (req_command == CMD_START)) tracking_in = 1'b1;
      else if (dp_cmd.finish && status.last) tracking_in = 1'b0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.finish) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tracking_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tracking_ff  <= tracking_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `PTT_ASSERT(run_only_tracking, clock, reset, state_ff == ST_ANG0, tracking_ff, "sample run while idle")
   `PTT_ASSERT_NEXT(last_ends_run, clock, reset, dp_cmd.finish && status.last, !tracking_ff, "run not ended on last sample")
   `PTT_ASSERT_NEXT(no_overwrite, clock, reset, (state_ff == ST_OUT) && rsp_valid_ff && !rsp_ready, (state_ff == ST_OUT) && rsp_valid_ff, "pending result overwritten")

endmodule

### design/pid_trajectory_tracker.sv
// PID position controller following a stored trajectory. Load transfers
// (command 0) write one Q16.16 desired angle into a 2048-entry trajectory
// memory; loads at an index beyond the memory are dropped. A start
// transfer (command 1) arms tracking. Each sample tick (command 2) while
// tracking converts the encoder count to degrees, forms the error against
// the current trajectory point, updates an integral clamped to +/-1000
// degrees and a difference term, and returns one result: the saturated
// torque, the measured angle, the point index and a last flag on the
// final point of the run, after which tracking drops back to idle. Ticks
// while idle and command 3 give no result. Loads, starts and result-free
// ticks each finish without holding off the next request; a tracked tick
// holds off the next request until its result is loaded into the output
// register. The sequencer steps through a reciprocal-multiply degree
// conversion (four steps), error, integral, three passes through one
// shared 32x32 multiplier, a final accumulate and the result step. The
// next transfer is taken while the result waits on the output register;
// a second result waits for the first to be taken. Trajectory entries
// read before being written hold arbitrary data; the memory has no
// clearing pass. Gains and run length sit behind an APB-style port at
// byte addresses 0, 4, 8 and 12.
module pid_trajectory_tracker (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ptt_pkg::CMD_W-1:0]         req_command,
   input  logic [ptt_pkg::IDX_W-1:0]         req_point_index,
   input  logic signed [ptt_pkg::DATA_W-1:0] req_point_angle,
   input  logic signed [ptt_pkg::ENC_W-1:0]  req_encoder_count,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ptt_pkg::DATA_W-1:0] rsp_torque,
   output logic signed [ptt_pkg::DATA_W-1:0] rsp_measured_angle,
   output logic [ptt_pkg::IDX_W-1:0]         rsp_sample_index,
   output logic                              rsp_last,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [ptt_pkg::CSR_AW-1:0]        paddr,
   input  logic [ptt_pkg::DATA_W-1:0]        pwdata,
   output logic [ptt_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);
   import ptt_pkg::*;

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // gains and run length; the user must write them only between runs, the block does not enforce it
   ptt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: owns the handshakes, the tracking flag and result valid
   ptt_control u_control (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (dp_status),
      .dp_cmd      (dp_cmd)
   );

   // trajectory memory, conversion, PID arithmetic and result registers
   ptt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (dp_cmd),
      .status         (dp_status),
      .point_index    (req_point_index),
      .point_angle    (req_point_angle),
      .encoder_count  (req_encoder_count),
      .torque         (rsp_torque),
      .measured_angle (rsp_measured_angle),
      .sample_index   (rsp_sample_index),
      .last           (rsp_last)
   );

endmodule
